@@ hdl/stc_pkg.sv @@
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants for the seconds to calendar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

    localparam int IN_W   = 32;
    localparam int OUT_W  = 48;
    localparam int DAYS_W = 16;
    localparam int TOD_W  = 17;
    localparam int MOD_W  = 11;

    localparam int DAY_SHIFT = 7;

    // floor(x / 675) = (x * DAY_RECIP) >> DAY_RECIP_SH for x < 2**25
    localparam logic [25:0] DAY_RECIP    = 26'd50903317;
    localparam int          DAY_RECIP_SH = 35;
    localparam logic [9:0]  DAY_ODD      = 10'd675;

    // floor(x / 15), x < 2**15
    localparam logic [15:0] MOD_RECIP    = 16'd34953;
    localparam int          MOD_RECIP_SH = 19;

    // floor(x / 15), x < 2**9
    localparam logic [9:0]  HOUR_RECIP    = 10'd547;
    localparam int          HOUR_RECIP_SH = 13;

    // floor(x / 7), x < 2**16
    localparam logic [16:0] WD_RECIP    = 17'd74899;
    localparam int          WD_RECIP_SH = 19;

    // floor(x / 1461), x < 2**16
    localparam logic [16:0] CYC_RECIP    = 17'd91868;
    localparam int          CYC_RECIP_SH = 27;

    localparam logic [10:0] DAYS_PER_CYCLE   = 11'd1461;
    localparam logic [10:0] LEAP_YEAR_DAYS   = 11'd366;
    localparam logic [10:0] COMMON_YEAR_DAYS = 11'd365;
    localparam logic [10:0] TWO_YEAR_DAYS    = 11'd730;
    localparam logic [5:0]  SIXTY            = 6'd60;
    localparam logic [11:0] BASE_YEAR        = 12'd2000;

    localparam logic [11:0][8:0] MONTH_START_COMMON = {
        9'd334, 9'd304, 9'd273, 9'd243, 9'd212, 9'd181,
        9'd151, 9'd120, 9'd90,  9'd59,  9'd31,  9'd0
    };
    localparam logic [11:0][8:0] MONTH_START_LEAP = {
        9'd335, 9'd305, 9'd274, 9'd244, 9'd213, 9'd182,
        9'd152, 9'd121, 9'd91,  9'd60,  9'd31,  9'd0
    };

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [TOD_W-1:0]  tod;
    } t_split;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] min;
        logic [5:0] sec;
    } t_clock;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  wd;
    } t_date;

endpackage

`default_nettype wire

@@ hdl/stc_day_split.sv @@
// ----------------------------------------------------------------------------
// stc_day_split
// Input register, then split of the seconds count into whole days and
// seconds of the day (stages 0 to 2).
// ----------------------------------------------------------------------------
`default_nettype none

module stc_day_split
    import stc_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [IN_W-1:0] i_count,
    output t_split               o_split
);

    logic [IN_W-1:0]           r_cnt;
    logic [IN_W-DAY_SHIFT-1:0] r1_q0;
    logic [DAY_SHIFT-1:0]      r1_lo;
    logic [DAYS_W-1:0]         r1_days;
    t_split                    r2_split;

    logic [IN_W-DAY_SHIFT-1:0] w_q0;
    logic [50:0]               w_prod;
    logic [IN_W-DAY_SHIFT-1:0] w_d675;
    logic [IN_W-DAY_SHIFT-1:0] w_rem;
    t_split                    n2_split;

    assign w_q0   = r_cnt[IN_W-1:DAY_SHIFT];
    assign w_prod = 51'(w_q0) * 51'(DAY_RECIP);

    assign w_d675 = 25'(r1_days) * 25'(DAY_ODD);
    assign w_rem  = r1_q0 - w_d675;

    always_comb begin
        n2_split.days = r1_days;
        n2_split.tod  = {w_rem[9:0], r1_lo};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cnt    <= i_count;
            r1_q0    <= w_q0;
            r1_lo    <= r_cnt[DAY_SHIFT-1:0];
            r1_days  <= w_prod[DAY_RECIP_SH+DAYS_W-1:DAY_RECIP_SH];
            r2_split <= n2_split;
        end
    end

    assign o_split = r2_split;

endmodule

`default_nettype wire

@@ hdl/stc_clock.sv @@
// ----------------------------------------------------------------------------
// stc_clock
// Seconds of the day to hour, minute and second (stages 3 to 6).
// ----------------------------------------------------------------------------
`default_nettype none

module stc_clock
    import stc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [TOD_W-1:0] i_tod,
    output t_clock                o_clock
);

    logic [TOD_W-1:0] r3_tod;
    logic [MOD_W-1:0] r3_mod;
    logic [MOD_W-1:0] r4_mod;
    logic [4:0]       r4_hour;
    logic [5:0]       r4_sec;
    logic [MOD_W-1:0] r5_mod;
    logic [MOD_W-1:0] r5_h60;
    logic [4:0]       r5_hour;
    logic [5:0]       r5_sec;
    t_clock           r6_clock;

    logic [30:0]      w_mprod;
    logic [18:0]      w_hprod;
    logic [TOD_W-1:0] w_m60;
    logic [TOD_W-1:0] w_sec;
    logic [MOD_W-1:0] w_min;
    t_clock           n6_clock;

    assign w_mprod = 31'(i_tod[TOD_W-1:2]) * 31'(MOD_RECIP);
    assign w_hprod = 19'(r3_mod[MOD_W-1:2]) * 19'(HOUR_RECIP);
    assign w_m60   = 17'(r3_mod) * 17'(SIXTY);
    assign w_sec   = r3_tod - w_m60;
    assign w_min   = r5_mod - r5_h60;

    always_comb begin
        n6_clock.hour = r5_hour;
        n6_clock.min  = w_min[5:0];
        n6_clock.sec  = r5_sec;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_tod   <= i_tod;
            r3_mod   <= w_mprod[MOD_RECIP_SH+MOD_W-1:MOD_RECIP_SH];
            r4_mod   <= r3_mod;
            r4_hour  <= w_hprod[HOUR_RECIP_SH+4:HOUR_RECIP_SH];
            r4_sec   <= w_sec[5:0];
            r5_mod   <= r4_mod;
            r5_h60   <= 11'(r4_hour) * 11'(SIXTY);
            r5_hour  <= r4_hour;
            r5_sec   <= r4_sec;
            r6_clock <= n6_clock;
        end
    end

    assign o_clock = r6_clock;

endmodule

`default_nettype wire

@@ hdl/stc_calendar.sv @@
// ----------------------------------------------------------------------------
// stc_calendar
// Day number to weekday, day of month, month and year over four-year
// cycles (stages 3 to 6).
// ----------------------------------------------------------------------------
`default_nettype none

module stc_calendar
    import stc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [DAYS_W-1:0] i_days,
    output t_date                  o_date
);

    logic [DAYS_W-1:0] r3_days;
    logic [12:0]       r3_q7;
    logic [5:0]        r3_cyc;
    logic [2:0]        r4_wd;
    logic [10:0]       r4_off;
    logic [5:0]        r4_cyc;
    logic [2:0]        r5_wd;
    logic [8:0]        r5_doy;
    logic              r5_leap;
    logic [11:0]       r5_year;
    t_date             r6_date;

    logic [32:0]       w_wprod;
    logic [32:0]       w_cprod;
    logic [DAYS_W-1:0] w_q7x7;
    logic [DAYS_W-1:0] w_wd;
    logic [DAYS_W-1:0] w_cx;
    logic [DAYS_W-1:0] w_off;
    logic [10:0]       n5_rest;
    logic [10:0]       n5_doy;
    logic [1:0]        n5_yoff;
    logic              n5_leap;
    logic [11:0]       n5_year;
    logic [3:0]        w_mon;
    logic [8:0]        w_start;
    logic [8:0]        w_dom;
    t_date             n6_date;

    assign w_wprod = 33'(i_days) * 33'(WD_RECIP);
    assign w_cprod = 33'(i_days) * 33'(CYC_RECIP);

    assign w_q7x7 = 16'(r3_q7) * 16'd7;
    assign w_wd   = r3_days - w_q7x7;
    assign w_cx   = 16'(r3_cyc) * 16'(DAYS_PER_CYCLE);
    assign w_off  = r3_days - w_cx;

    always_comb begin
        n5_leap = (r4_off < LEAP_YEAR_DAYS);
        n5_rest = r4_off - LEAP_YEAR_DAYS;
        if (n5_leap) begin
            n5_yoff = 2'd0;
            n5_doy  = r4_off;
        end else if (n5_rest >= TWO_YEAR_DAYS) begin
            n5_yoff = 2'd3;
            n5_doy  = n5_rest - TWO_YEAR_DAYS;
        end else if (n5_rest >= COMMON_YEAR_DAYS) begin
            n5_yoff = 2'd2;
            n5_doy  = n5_rest - COMMON_YEAR_DAYS;
        end else begin
            n5_yoff = 2'd1;
            n5_doy  = n5_rest;
        end
        n5_year = BASE_YEAR + {4'd0, r4_cyc, 2'b00} + 12'(n5_yoff);
    end

    always_comb begin
        w_mon = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (r5_doy >= (r5_leap ? MONTH_START_LEAP[i] : MONTH_START_COMMON[i])) begin
                w_mon = 4'(i);
            end
        end
        w_start = r5_leap ? MONTH_START_LEAP[w_mon] : MONTH_START_COMMON[w_mon];
        w_dom   = r5_doy - w_start + 9'd1;
        n6_date.year  = r5_year;
        n6_date.month = w_mon + 4'd1;
        n6_date.day   = w_dom[4:0];
        n6_date.wd    = r5_wd;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_days <= i_days;
            r3_q7   <= w_wprod[WD_RECIP_SH+12:WD_RECIP_SH];
            r3_cyc  <= w_cprod[CYC_RECIP_SH+5:CYC_RECIP_SH];
            r4_wd   <= w_wd[2:0];
            r4_off  <= w_off[10:0];
            r4_cyc  <= r3_cyc;
            r5_wd   <= r4_wd;
            r5_doy  <= n5_doy[8:0];
            r5_leap <= n5_leap;
            r5_year <= n5_year;
            r6_date <= n6_date;
        end
    end

    assign o_date = r6_date;

endmodule

`default_nettype wire

@@ hdl/seconds_to_calendar_core.sv @@
// ----------------------------------------------------------------------------
// seconds_to_calendar_core
// Converts a seconds count from 2000-01-01 00:00:00 into time of day,
// weekday and calendar date, one transfer per cycle while m_axis is not stalled.
//
//   channel   dir   tdata bits (low to high)
//   s_axis    in    seconds_count[31:0]
//   m_axis    out   second, minute, hour, weekday, day, month, year, pad
//
// One transfer in per cycle, one transfer out per cycle, while the output is not stalled.
// The pipeline has seven register stages; its depth is set by the chain of
// constant reciprocal multiplies.
// Reset clears the stage valid bits only.
// A stalled output freezes all seven stages and drops s_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module seconds_to_calendar_core
    import stc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_axis_tvalid,
    output      logic             o_s_axis_tready,
    input  wire logic [IN_W-1:0]  i_s_axis_tdata,   // seconds_count[31:0]
    output      logic             o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    // second_of_minute[5:0], minute_of_hour[11:6], hour_of_day[16:12],
    // weekday[19:17], day_of_month[24:20], month_number[28:25],
    // year_number[40:29], zero pad[47:41]
    output      logic [OUT_W-1:0] o_m_axis_tdata
);

    localparam int STAGES = 7;

    logic [STAGES-1:0] r_vld;
    logic              w_en;
    t_split            w_split;
    t_clock            w_clock;
    t_date             w_date;

    assign w_en            = ~r_vld[STAGES-1] | i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_s_axis_tvalid};
        end
    end

    stc_day_split u_split (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_count (i_s_axis_tdata),
        .o_split (w_split)
    );

    stc_clock u_clock (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_tod   (w_split.tod),
        .o_clock (w_clock)
    );

    stc_calendar u_calendar (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_days (w_split.days),
        .o_date (w_date)
    );

    assign o_m_axis_tdata = {7'd0, w_date.year, w_date.month, w_date.day, w_date.wd,
                             w_clock.hour, w_clock.min, w_clock.sec};

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_clock.sec < 6'd60) && (w_clock.min < 6'd60) &&
                            (w_clock.hour < 5'd24) && (w_date.wd < 3'd7))
        else $error("time of day field out of range");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_date.day >= 5'd1) && (w_date.month >= 4'd1) &&
                            (w_date.month <= 4'd12) && (w_date.year >= 12'd2000) &&
                            (w_date.year <= 12'd2136))
        else $error("date field out of range");

    a_feb_days: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (w_date.month == 4'd2)) |-> (w_date.day <= 5'd29))
        else $error("day of month past end of February");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while output held");

endmodule

`default_nettype wire
